FILE: rtl/core/rtdim_pkg.sv
// ----------------------------------------------------------------------------
// rtdim_pkg
// Shared constants, controller/datapath command types and the level scaling
// function for the throttle-driven segment dimmer.
// ----------------------------------------------------------------------------
package rtdim_pkg;

    // Field widths
    localparam int ChWidth      = 11;
    localparam int TimerWidth   = 16;
    localparam int ElapsedWidth = 8;
    localparam int LevelWidth   = 8;
    localparam int SegCount     = 4;
    localparam int SegIdxWidth  = 2;

    // Stream payload widths
    localparam int InDataWidth  = 24;
    localparam int OutDataWidth = SegCount * LevelWidth;

    // Shared multiplier operand widths
    localparam int MulAWidth = 15;
    localparam int MulBWidth = 32;
    localparam int MulPWidth = MulAWidth + MulBWidth;

    // Channel handling
    localparam logic [ChWidth-1:0]    FAILSAFE_CH   = 11'd992;
    localparam logic [ChWidth-1:0]    CH_MIN        = 11'd191;
    localparam logic [TimerWidth-1:0] TIMEOUT_RESET = 16'd100;
    localparam logic [TimerWidth-1:0] TIMER_MAX     = 16'hFFFF;

    // Mapping x*1023/1602: estimate with floor(2^32/1602)*1023, then one fixup
    localparam logic [MulBWidth-1:0] MAP_RECIP = 32'd2742666069;
    localparam logic [ChWidth-1:0]   MAP_DIV   = 11'd1602;

    // Smoothing divide by 100 as (v*5243)>>19, exact for v below 25600
    localparam logic [12:0] AVG_RECIP = 13'd5243;
    localparam int          AvgShift  = 19;

    // Level clamp
    localparam logic [6:0] LEVEL_CAP = 7'd55;
    localparam logic [6:0] OFFS_SEG1 = 7'd10;
    localparam logic [6:0] OFFS_STD  = 7'd9;

    // Controller to datapath commands
    typedef struct packed {
        logic                   load;
        logic                   map_mul;
        logic                   map_fix;
        logic                   level_upd;
        logic                   smooth;
        logic [SegIdxWidth-1:0] seg_idx;
        logic                   out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Scale a clamped level 0..55 onto 0..255 as t*51/11, truncated
    function automatic logic [LevelWidth-1:0] scale_level(input logic [5:0] t);
        logic [11:0] v;
        logic [23:0] p;
        v = 12'(t) * 12'd51;
        p = 24'(v) * 24'd2979;
        return p[22:15];
    endfunction

endpackage

FILE: rtl/core/rtdim_ctrl.sv
// ----------------------------------------------------------------------------
// rtdim_ctrl
// Sequencer for one tick: accept, map the channel in two multiplier passes,
// update a segment level, smooth the four segments, then hand off the result.
// ----------------------------------------------------------------------------
module rtdim_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  rtdim_pkg::dp_status_t  status,
    output rtdim_pkg::dp_cmd_t     cmd
);

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_MAP_MUL = 6'b000010,
        ST_MAP_FIX = 6'b000100,
        ST_LEVEL   = 6'b001000,
        ST_SMOOTH  = 6'b010000,
        ST_DONE    = 6'b100000
    } state_t;

    state_t                           state_reg;
    state_t                           state_next;
    logic [rtdim_pkg::SegIdxWidth-1:0] seg_reg;
    logic [rtdim_pkg::SegIdxWidth-1:0] seg_next;

    // Advance the state and segment counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            seg_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
        end
    end

    // Decode state into commands and next state
    always_comb
    begin
        state_next  = state_reg;
        seg_next    = seg_reg;
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.seg_idx = seg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MAP_MUL;
                end
            end
            ST_MAP_MUL:
            begin
                cmd.map_mul = 1'b1;
                state_next  = ST_MAP_FIX;
            end
            ST_MAP_FIX:
            begin
                cmd.map_fix = 1'b1;
                state_next  = ST_LEVEL;
            end
            ST_LEVEL:
            begin
                cmd.level_upd = 1'b1;
                seg_next      = '0;
                state_next    = ST_SMOOTH;
            end
            ST_SMOOTH:
            begin
                cmd.smooth = 1'b1;
                seg_next   = seg_reg + 1'b1;
                if (seg_reg == rtdim_pkg::SegIdxWidth'(rtdim_pkg::SegCount - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                // Hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/rtdim_dp.sv
// ----------------------------------------------------------------------------
// rtdim_dp
// Datapath: frame timer, held channel, shared multiplier for channel mapping
// and smoothing, segment level and average registers, output register.
// ----------------------------------------------------------------------------
module rtdim_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  rtdim_pkg::dp_cmd_t                   cmd,
    output rtdim_pkg::dp_status_t                status,
    input  logic                                 new_frame,
    input  logic [rtdim_pkg::ChWidth-1:0]        throttle_raw,
    input  logic [rtdim_pkg::ElapsedWidth-1:0]   elapsed_ms,
    input  logic                                 cfg_wr,
    input  logic [rtdim_pkg::TimerWidth-1:0]     cfg_value,
    output logic [rtdim_pkg::OutDataWidth-1:0]   out_data,
    output logic                                 out_lost,
    output logic                                 out_valid,
    input  logic                                 out_taken
);

    logic [rtdim_pkg::TimerWidth-1:0] timeout_reg;
    logic [rtdim_pkg::TimerWidth-1:0] ms_reg;
    logic [rtdim_pkg::ChWidth-1:0]    held_reg;
    logic                             lost_reg;
    logic                             neg_reg;
    logic [20:0]                      p_reg;
    logic [rtdim_pkg::ChWidth-1:0]    q_reg;
    logic [rtdim_pkg::ChWidth-1:0]    m_reg;
    logic [rtdim_pkg::LevelWidth-1:0] level_reg [rtdim_pkg::SegCount];
    logic [rtdim_pkg::LevelWidth-1:0] avg_reg   [rtdim_pkg::SegCount];
    logic [rtdim_pkg::OutDataWidth-1:0] out_data_reg;
    logic                             out_lost_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;

    // Tick front end
    logic [rtdim_pkg::TimerWidth:0]   ms_sum;
    logic [rtdim_pkg::TimerWidth-1:0] ms_next;
    logic [rtdim_pkg::ChWidth-1:0]    held_pick;
    logic                             lost_next;

    // Mapping
    logic                             ch_low;
    logic [rtdim_pkg::ChWidth-1:0]    x_u;
    logic [20:0]                      p_next;
    logic [20:0]                      r_val;
    logic [rtdim_pkg::ChWidth-1:0]    m_next;

    // Level update
    logic                             in_range;
    logic [1:0]                       seg_sel;
    logic [6:0]                       masked;
    logic [6:0]                       offs;
    logic [6:0]                       diff;
    logic [5:0]                       t_clamp;

    // Smoothing
    logic [rtdim_pkg::MulAWidth-1:0]  blend;

    // Shared multiplier
    logic [rtdim_pkg::MulAWidth-1:0]  mul_a;
    logic [rtdim_pkg::MulBWidth-1:0]  mul_b;
    logic [rtdim_pkg::MulPWidth-1:0]  mul_p;

    // Saturating timer, frame capture and timeout check
    always_comb
    begin
        ms_sum = {1'b0, ms_reg} + (rtdim_pkg::TimerWidth + 1)'(elapsed_ms);
        if (new_frame)
        begin
            ms_next   = '0;
            held_pick = throttle_raw;
        end
        else
        begin
            ms_next   = ms_sum[rtdim_pkg::TimerWidth] ? rtdim_pkg::TIMER_MAX
                                                      : ms_sum[rtdim_pkg::TimerWidth-1:0];
            held_pick = held_reg;
        end
        lost_next = (ms_next > timeout_reg);
    end

    // Offset channel and x*1023
    always_comb
    begin
        ch_low = (held_reg < rtdim_pkg::CH_MIN);
        x_u    = held_reg - rtdim_pkg::CH_MIN;
        p_next = {x_u, 10'b0} - 21'(x_u);
    end

    // Select multiplier operands per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (cmd.map_mul)
        begin
            mul_a = rtdim_pkg::MulAWidth'(x_u);
            mul_b = rtdim_pkg::MAP_RECIP;
        end
        else if (cmd.map_fix)
        begin
            mul_a = rtdim_pkg::MulAWidth'(q_reg);
            mul_b = rtdim_pkg::MulBWidth'(rtdim_pkg::MAP_DIV);
        end
        else if (cmd.smooth)
        begin
            mul_a = blend;
            mul_b = rtdim_pkg::MulBWidth'(rtdim_pkg::AVG_RECIP);
        end
    end

    assign mul_p = rtdim_pkg::MulPWidth'(mul_a) * rtdim_pkg::MulPWidth'(mul_b);

    // Fix up the quotient estimate by one
    always_comb
    begin
        r_val  = p_reg - mul_p[20:0];
        m_next = (r_val >= 21'(rtdim_pkg::MAP_DIV)) ? q_reg + 1'b1 : q_reg;
    end

    // Segment select and clamped level
    always_comb
    begin
        in_range = !neg_reg && (m_reg[10:9] == 2'b01);
        seg_sel  = m_reg[8:7];
        masked   = {m_reg[6:1], 1'b0};
        offs     = (seg_sel == 2'd1) ? rtdim_pkg::OFFS_SEG1 : rtdim_pkg::OFFS_STD;
        diff     = masked - offs;
        if (masked < offs)
        begin
            t_clamp = '0;
        end
        else if (diff > rtdim_pkg::LEVEL_CAP)
        begin
            t_clamp = rtdim_pkg::LEVEL_CAP[5:0];
        end
        else
        begin
            t_clamp = diff[5:0];
        end
    end

    // 85*avg + 15*level for the segment being smoothed
    always_comb
    begin
        blend = rtdim_pkg::MulAWidth'(avg_reg[cmd.seg_idx]) * 15'd85
              + rtdim_pkg::MulAWidth'(level_reg[cmd.seg_idx]) * 15'd15;
    end

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= rtdim_pkg::TIMEOUT_RESET;
        end
        else if (cfg_wr)
        begin
            timeout_reg <= cfg_value;
        end
    end

    // Timer, held channel and link state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_reg   <= rtdim_pkg::TIMER_MAX;
            held_reg <= rtdim_pkg::FAILSAFE_CH;
            lost_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            ms_reg   <= ms_next;
            held_reg <= lost_next ? rtdim_pkg::FAILSAFE_CH : held_pick;
            lost_reg <= lost_next;
        end
    end

    // Mapping pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.map_mul)
        begin
            neg_reg <= ch_low;
            p_reg   <= p_next;
            q_reg   <= mul_p[42:32];
        end
        if (cmd.map_fix)
        begin
            m_reg <= m_next;
        end
    end

    // Segment levels and averages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < rtdim_pkg::SegCount; i++)
            begin
                level_reg[i] <= '0;
                avg_reg[i]   <= '0;
            end
        end
        else
        begin
            if (cmd.level_upd && in_range)
            begin
                level_reg[seg_sel] <= rtdim_pkg::scale_level(t_clamp);
            end
            if (cmd.smooth)
            begin
                avg_reg[cmd.seg_idx] <=
                    mul_p[rtdim_pkg::AvgShift +: rtdim_pkg::LevelWidth];
            end
        end
    end

    // Output register and its valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_taken)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int i = 0; i < rtdim_pkg::SegCount; i++)
            begin
                out_data_reg[i*rtdim_pkg::LevelWidth +: rtdim_pkg::LevelWidth] <=
                    8'hFF - avg_reg[i];
            end
            out_lost_reg <= lost_reg;
        end
    end

    assign status.out_free = !out_valid_reg || out_taken;
    assign out_data        = out_data_reg;
    assign out_lost        = out_lost_reg;
    assign out_valid       = out_valid_reg;

endmodule

FILE: rtl/core/rc_throttle_segment_led_dimmer.sv
// ----------------------------------------------------------------------------
// rc_throttle_segment_led_dimmer
// Radio throttle channel to four smoothed, active-low LED segment duties.
// ----------------------------------------------------------------------------
// Each accepted transaction is one control tick and yields one result
// transaction. From one acceptance to the next a tick runs the accept, two
// passes through the shared multiplier to map the channel, one level update,
// four smoothing passes (one segment per cycle through the same multiplier)
// and the output register load. The result sits in an output register, so
// the next tick is accepted while it waits; if it is still not taken when
// the next result is ready, the block holds. The timer resets saturated, so
// at the reset timeout a tick before the first frame reports link lost.
// lost_timeout_ms is written through the cfg channel, which is always ready.
module rc_throttle_segment_led_dimmer (
    input  logic        clk,
    input  logic        rst_n,
    // Input ticks
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [10:0] throttle_raw, [18:11] elapsed_ms
    input  logic        s_axis_tuser,   // [0] new_frame
    // Results
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] duty_seg0, [15:8] duty_seg1,
                                        // [23:16] duty_seg2, [31:24] duty_seg3
    output logic        m_axis_tuser,   // [0] link_lost
    // Configuration
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data        // lost_timeout_ms
);

    rtdim_pkg::dp_cmd_t    cmd;
    rtdim_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    rtdim_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    rtdim_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .new_frame    (s_axis_tuser),
        .throttle_raw (s_axis_tdata[10:0]),
        .elapsed_ms   (s_axis_tdata[18:11]),
        .cfg_wr       (cfg_valid),
        .cfg_value    (cfg_data),
        .out_data     (m_axis_tdata),
        .out_lost     (m_axis_tuser),
        .out_valid    (m_axis_tvalid),
        .out_taken    (m_axis_tready)
    );

endmodule
